// ===== src/lcts_pkg.sv =====
// Shared types, constants and helpers for the load-cell tare and smoothing block.
package lcts_pkg;

    localparam int CH_MAX    = 4;
    localparam int SAMPLE_W  = 24;
    localparam int WORD_W    = 32;
    localparam int ALPHA_W   = 16;
    localparam int SCALE_W   = 20;
    localparam int COUNT_W   = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int ACC_W     = 56;
    localparam int MUL_X_W   = 33;
    localparam int MUL_Y_W   = 21;
    localparam int PROD_W    = MUL_X_W + MUL_Y_W;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 256;

    localparam logic [WORD_W-1:0] TARE_SEED [CH_MAX] = '{
        32'd2124412800, 32'd2219652608, 32'd2206095360, 32'd2333550336
    };
    localparam logic [SCALE_W-1:0] SCALE_RESET [CH_MAX] = '{
        20'd9538, 20'd12218, 20'd10812, 20'd10044
    };
    localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 16'd58982;
    localparam logic [ALPHA_W-1:0] TARE_N_RESET = 16'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA   = 3'd0,
        CFG_TARE_N  = 3'd1,
        CFG_SCALE_1 = 3'd2,
        CFG_SCALE_2 = 3'd3,
        CFG_SCALE_3 = 3'd4,
        CFG_SCALE_4 = 3'd5
    } t_cfg_idx;

    // One memory word per channel.
    typedef struct packed {
        logic        [WORD_W-1:0] tare;
        logic signed [WORD_W-1:0] smooth;
        logic signed [WORD_W-1:0] inst;
    } t_entry;

    typedef enum logic [2:0] {
        MAC_IDLE   = 3'd0,
        MAC_TARE_A = 3'd1,
        MAC_TARE_B = 3'd2,
        MAC_WT_A   = 3'd3,
        MAC_WT_B   = 3'd4,
        MAC_WT_C   = 3'd5
    } t_mac_op;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_MUL_A = 7'b0000100,
        ST_MUL_B = 7'b0001000,
        ST_MUL_C = 7'b0010000,
        ST_WRITE = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic           rd_en;
        logic           wr_en;
        logic           clear;
    } t_mem_ctl;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7FFF_FFFF);
        lo = -ACC_W'(33'sh0_8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

// ===== src/lcts_state_mem.sv =====
// Per-channel state memory with registered read and reset-to-seed valid bits.
module lcts_state_mem #(
    parameter int CHANNELS = 4,
    parameter int CH_W     = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lcts_pkg::t_mem_ctl   i_ctl,
    input  logic [CH_W-1:0]      i_addr,
    input  lcts_pkg::t_entry     i_wr_data,
    output lcts_pkg::t_entry     o_rd_data
);

    lcts_pkg::t_entry r_mem [CHANNELS];
    lcts_pkg::t_entry r_rd_data;
    logic [CH_W-1:0]  r_rd_addr;
    logic             r_rd_vld;
    logic [CHANNELS-1:0] r_vld;
    logic [CHANNELS-1:0] n_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
            r_rd_addr <= i_addr;
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (i_ctl.clear) begin
            n_vld = '0;
        end else if (i_ctl.wr_en) begin
            n_vld[i_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_addr];
            end
        end
    end

    // An entry never written since reset or clear reads as its seed.
    always_comb begin
        if (r_rd_vld) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data.tare   = lcts_pkg::TARE_SEED[2'(r_rd_addr)];
            o_rd_data.smooth = '0;
            o_rd_data.inst   = '0;
        end
    end

endmodule

// ===== src/lcts_mac.sv =====
// Shared multiply-accumulate unit for the tare and weight updates.
module lcts_mac (
    input  logic                                   i_clk,
    input  lcts_pkg::t_mac_op                      i_op,
    input  logic        [lcts_pkg::WORD_W-1:0]     i_tare,
    input  logic signed [lcts_pkg::WORD_W-1:0]     i_smooth,
    input  logic        [lcts_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic        [lcts_pkg::ALPHA_W-1:0]    i_alpha,
    input  logic        [lcts_pkg::SCALE_W-1:0]    i_scale,
    output logic        [lcts_pkg::WORD_W-1:0]     o_tare,
    output logic signed [lcts_pkg::WORD_W-1:0]     o_smooth,
    output logic signed [lcts_pkg::WORD_W-1:0]     o_inst
);

    localparam int ACC_W = lcts_pkg::ACC_W;

    logic        [lcts_pkg::WORD_W-1:0]  s8;
    logic        [lcts_pkg::ALPHA_W:0]   na;
    logic signed [lcts_pkg::MUL_X_W-1:0] x;
    logic signed [lcts_pkg::MUL_Y_W-1:0] y;
    logic signed [lcts_pkg::PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]             r_acc;
    logic signed [ACC_W-1:0]             acc_r16;
    logic signed [ACC_W-1:0]             acc_r24;
    logic signed [ACC_W-1:0]             acc_s16;
    logic signed [lcts_pkg::WORD_W-1:0]  r_w;

    assign s8 = {i_sample, 8'h00};
    assign na = 17'h1_0000 - {1'b0, i_alpha};

    always_comb begin
        x = '0;
        y = '0;
        unique case (i_op)
            lcts_pkg::MAC_IDLE: begin
            end
            lcts_pkg::MAC_TARE_A: begin
                x = $signed({1'b0, i_tare});
                y = $signed({5'b0, i_alpha});
            end
            lcts_pkg::MAC_TARE_B: begin
                x = $signed({1'b0, s8});
                y = $signed({4'b0, na});
            end
            lcts_pkg::MAC_WT_A: begin
                x = $signed({1'b0, s8}) - $signed({1'b0, i_tare});
                y = $signed({1'b0, i_scale});
            end
            lcts_pkg::MAC_WT_B: begin
                x = lcts_pkg::MUL_X_W'(i_smooth);
                y = $signed({5'b0, i_alpha});
            end
            lcts_pkg::MAC_WT_C: begin
                x = lcts_pkg::MUL_X_W'(r_w);
                y = $signed({4'b0, na});
            end
            default: begin
            end
        endcase
    end

    assign prod    = x * y;
    assign acc_r16 = r_acc + ACC_W'(32'sd32768);
    assign acc_r24 = r_acc + ACC_W'(32'sd8388608);
    assign acc_s16 = acc_r16 >>> 16;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            lcts_pkg::MAC_TARE_A, lcts_pkg::MAC_WT_A: begin
                r_acc <= ACC_W'(prod);
            end
            lcts_pkg::MAC_TARE_B, lcts_pkg::MAC_WT_C: begin
                r_acc <= r_acc + ACC_W'(prod);
            end
            lcts_pkg::MAC_WT_B: begin
                // The product of the first step becomes the instant weight while
                // the old smoothed value is multiplied.
                r_w   <= lcts_pkg::sat32(acc_r24 >>> 24);
                r_acc <= ACC_W'(prod);
            end
            default: begin
            end
        endcase
    end

    assign o_tare   = acc_r16[47:16];
    assign o_smooth = lcts_pkg::sat32(acc_s16);
    assign o_inst   = r_w;

endmodule

// ===== src/load_cell_tare_and_smooth_top.sv =====
// Load-cell tare and smoothing block: top level with sequencer, registers and stream ports.
//
// Each input transaction carries four 24-bit load-cell samples and a clear flag and yields
// one result transaction. The first tare_samples+1 transactions after reset or clear update
// each channel's tare by a moving average; after that each channel gives an instant weight
// (sample minus tare, times scale) and a moving-average smoothed weight, both Q15.16 kg.
// After a transaction is accepted, each channel in turn is read, run through the multiply
// steps MUL_A, MUL_B and MUL_C and written back, and the result then goes to the output
// register; the sequence is set by the single multiply-accumulate unit and the one-port
// state memory, which each channel visits in turn. A new transaction is accepted while
// the previous result still waits on the output. Configuration writes are taken at any time
// and should be made while the block is idle.
module load_cell_tare_and_smooth_top #(
    parameter int CHANNELS = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // tdata: sample_1[23:0], sample_2[47:24], sample_3[71:48], sample_4[95:72]
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [lcts_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // tuser: clear
    input  logic                                  s_axis_tuser,
    // tdata: weight_1..weight_4 [127:0], then smoothed_1..smoothed_4 [255:128], 32 bits each
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [lcts_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // tuser: calibrating
    output logic                                  m_axis_tuser,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lcts_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lcts_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW   = lcts_pkg::SAMPLE_W;
    localparam int WW   = lcts_pkg::WORD_W;

    lcts_pkg::t_state r_state;
    lcts_pkg::t_state n_state;
    logic [CH_W-1:0]  r_ch;
    logic             r_taring;
    logic             r_clr;
    logic [lcts_pkg::COUNT_W-1:0] r_count;

    logic [lcts_pkg::ALPHA_W-1:0] r_alpha;
    logic [lcts_pkg::ALPHA_W-1:0] r_tare_n;
    logic [lcts_pkg::SCALE_W-1:0] r_scale [lcts_pkg::CH_MAX];

    logic [SW-1:0]           r_smp   [CHANNELS];
    logic signed [WW-1:0]    r_res_w [CHANNELS];
    logic signed [WW-1:0]    r_res_s [CHANNELS];

    logic                               r_m_valid;
    logic [lcts_pkg::OUT_DATA_W-1:0]    r_m_data;
    logic                               r_m_user;
    logic [lcts_pkg::OUT_DATA_W-1:0]    out_data;

    logic                 in_accept;
    logic                 out_load;
    logic                 last_ch;
    logic                 taring_now;
    lcts_pkg::t_mem_ctl   mem_ctl;
    lcts_pkg::t_entry     rd_data;
    lcts_pkg::t_entry     wr_data;
    lcts_pkg::t_mac_op    mac_op;
    logic [WW-1:0]        mac_tare;
    logic signed [WW-1:0] mac_smooth;
    logic signed [WW-1:0] mac_inst;

    assign s_axis_tready = (r_state == lcts_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign taring_now    = (r_count <= {1'b0, r_tare_n});
    assign last_ch       = (r_ch == CH_W'(CHANNELS - 1));
    assign out_load      = (r_state == lcts_pkg::ST_OUT) && (!r_m_valid || m_axis_tready);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= lcts_pkg::ALPHA_RESET;
            r_tare_n <= lcts_pkg::TARE_N_RESET;
            for (int i = 0; i < lcts_pkg::CH_MAX; i++) begin
                r_scale[i] <= lcts_pkg::SCALE_RESET[i];
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (lcts_pkg::t_cfg_idx'(i_cfg_index))
                lcts_pkg::CFG_ALPHA:   r_alpha    <= i_cfg_data[lcts_pkg::ALPHA_W-1:0];
                lcts_pkg::CFG_TARE_N:  r_tare_n   <= i_cfg_data[lcts_pkg::ALPHA_W-1:0];
                lcts_pkg::CFG_SCALE_1: r_scale[0] <= i_cfg_data;
                lcts_pkg::CFG_SCALE_2: r_scale[1] <= i_cfg_data;
                lcts_pkg::CFG_SCALE_3: r_scale[2] <= i_cfg_data;
                lcts_pkg::CFG_SCALE_4: r_scale[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer: each channel is read, run through the multiplier, and written back.
    always_comb begin
        n_state = r_state;
        mac_op  = lcts_pkg::MAC_IDLE;
        unique case (r_state)
            lcts_pkg::ST_IDLE: begin
                if (in_accept) n_state = lcts_pkg::ST_READ;
            end
            lcts_pkg::ST_READ: n_state = lcts_pkg::ST_MUL_A;
            lcts_pkg::ST_MUL_A: begin
                mac_op  = r_taring ? lcts_pkg::MAC_TARE_A : lcts_pkg::MAC_WT_A;
                n_state = lcts_pkg::ST_MUL_B;
            end
            lcts_pkg::ST_MUL_B: begin
                mac_op  = r_taring ? lcts_pkg::MAC_TARE_B : lcts_pkg::MAC_WT_B;
                n_state = lcts_pkg::ST_MUL_C;
            end
            lcts_pkg::ST_MUL_C: begin
                mac_op  = r_taring ? lcts_pkg::MAC_IDLE : lcts_pkg::MAC_WT_C;
                n_state = lcts_pkg::ST_WRITE;
            end
            lcts_pkg::ST_WRITE: n_state = last_ch ? lcts_pkg::ST_OUT : lcts_pkg::ST_READ;
            lcts_pkg::ST_OUT: begin
                if (out_load) n_state = lcts_pkg::ST_IDLE;
            end
            default: n_state = lcts_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcts_pkg::ST_IDLE;
            r_count <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_ch <= '0;
                if (s_axis_tuser) begin
                    r_count <= '0;
                end else if (taring_now) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (r_state == lcts_pkg::ST_WRITE && !last_ch) begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_taring <= taring_now;
            r_clr    <= s_axis_tuser;
            for (int i = 0; i < CHANNELS; i++) begin
                r_smp[i] <= s_axis_tdata[i*SW +: SW];
            end
        end
        if (r_state == lcts_pkg::ST_WRITE) begin
            r_res_w[r_ch] <= wr_data.inst;
            r_res_s[r_ch] <= wr_data.smooth;
        end
    end

    assign mem_ctl.rd_en = (r_state == lcts_pkg::ST_READ);
    assign mem_ctl.wr_en = (r_state == lcts_pkg::ST_WRITE);
    assign mem_ctl.clear = out_load && r_clr;

    always_comb begin
        wr_data = rd_data;
        if (r_taring) begin
            wr_data.tare = mac_tare;
        end else begin
            wr_data.smooth = mac_smooth;
            wr_data.inst   = mac_inst;
        end
    end

    lcts_state_mem #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_addr    (r_ch),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    lcts_mac u_mac (
        .i_clk    (i_clk),
        .i_op     (mac_op),
        .i_tare   (rd_data.tare),
        .i_smooth (rd_data.smooth),
        .i_sample (r_smp[r_ch]),
        .i_alpha  (r_alpha),
        .i_scale  (r_scale[2'(r_ch)]),
        .o_tare   (mac_tare),
        .o_smooth (mac_smooth),
        .o_inst   (mac_inst)
    );

    // Result word: unused channels and clear transactions report zero.
    for (genvar c = 0; c < lcts_pkg::CH_MAX; c++) begin : g_out
        if (c < CHANNELS) begin : g_used
            assign out_data[c*WW +: WW]                    = r_clr ? '0 : r_res_w[c];
            assign out_data[(lcts_pkg::CH_MAX + c)*WW +: WW] = r_clr ? '0 : r_res_s[c];
        end else begin : g_unused
            assign out_data[c*WW +: WW]                    = '0;
            assign out_data[(lcts_pkg::CH_MAX + c)*WW +: WW] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= out_data;
            r_m_user <= r_taring;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

// ===== src/lcts_checker.sv =====
// Port-level checks for the load-cell tare and smoothing block, bound to its top level.
module lcts_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [lcts_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again while busy");

    // A result valid does not rise too early after an accepted input.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 !$rose(m_axis_tvalid))
        else $error("result appeared too early");

endmodule

bind load_cell_tare_and_smooth_top lcts_checker u_lcts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
